FILE: src/aecb_pkg.sv
`default_nettype none

package aecb_pkg;

  // Line store geometry
  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ADDR_W    = COL_W + 1;
  localparam int MEM_DEPTH = 2 * MAX_WIDTH;
  localparam int ROW_W     = 16;
  localparam int WID_W     = 12;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PREMULTIPLY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_RED       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_GREEN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_BLUE      = 3'd6;

  // Neighbor slots
  localparam int NB_LEFT  = 0;
  localparam int NB_UP    = 1;
  localparam int NB_RIGHT = 2;
  localparam int NB_DOWN  = 3;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  // One pixel to finish: center, cross neighbors and position
  typedef struct packed {
    pix_t             center;
    pix_t [3:0]       nb;
    logic [3:0]       has;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             done;
  } job_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic             done;
  } res_t;

  typedef struct packed {
    logic       premul;
    logic       blend;
    logic [7:0] bg_red;
    logic [7:0] bg_green;
    logic [7:0] bg_blue;
  } fcfg_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_RD0,
    SQ_RD1,
    SQ_RD2,
    SQ_RD3,
    SQ_START,
    SQ_WAIT,
    SQ_PUSH
  } seq_state_t;

  typedef enum logic [2:0] {
    FL_IDLE,
    FL_ACC,
    FL_DSET,
    FL_DIV,
    FL_MUL1,
    FL_MIX,
    FL_MUL2,
    FL_FIN
  } flt_state_t;

endpackage

`default_nettype wire

FILE: src/aecb_in_if.sv
`default_nettype none

interface aecb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic [7:0] in_alpha;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  output in_alpha, input ready);
  modport sink (input valid, input in_red, input in_green, input in_blue,
                input in_alpha, output ready);
endinterface

`default_nettype wire

FILE: src/aecb_out_if.sv
`default_nettype none

interface aecb_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] out_col;
  logic [15:0] out_row;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic        image_done;

  modport source (output valid, output out_col, output out_row, output out_red,
                  output out_green, output out_blue, output out_alpha,
                  output image_done, input ready);
  modport sink (input valid, input out_col, input out_row, input out_red,
                input out_green, input out_blue, input out_alpha,
                input image_done, output ready);
endinterface

`default_nettype wire

FILE: src/aecb_line_mem.sv
`default_nettype none

module aecb_line_mem
  import aecb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire pix_t              wdata,
  input  wire logic [ADDR_W-1:0] raddr_a,
  input  wire logic [ADDR_W-1:0] raddr_b,
  output pix_t                   rdata_a,
  output pix_t                   rdata_b
);

  pix_t mem [MEM_DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // two registered read ports
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

FILE: src/aecb_filter.sv
`default_nettype none

module aecb_filter
  import aecb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  input  wire job_t  job,
  input  wire fcfg_t fcfg,
  output logic       done,
  output res_t       res
);

  function automatic logic [2:0][7:0] rgb(pix_t p);
    return {p.blue, p.green, p.red};
  endfunction

  flt_state_t st_r, st_nxt;

  job_t             job_r;
  logic [4:0]       cnt_r;
  logic [9:0]       sum_r;
  logic [16:0]      f_r;
  logic [16:0]      inv_r;
  logic [2:0][17:0] num_r;
  logic [2:0][9:0]  rem_r;
  logic [2:0][23:0] sh_r;
  logic [2:0][40:0] p1_r;
  logic [2:0][24:0] cf_r;
  logic [2:0][23:0] m_r;
  logic [2:0][40:0] p2_r;
  logic [2:0][24:0] bgi_r;
  logic             done_r;
  res_t             res_r;

  logic             acc_last;
  logic             div_last;
  logic             fin;

  logic [7:0]       ac;
  logic [2:0][7:0]  cc;
  logic [2:0][7:0]  bg;
  pix_t             nb_cur;
  logic [7:0]       w_cur;
  logic [16:0]      f_in;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      FL_IDLE: if (start) st_nxt = FL_ACC;
      FL_ACC:  if (acc_last) st_nxt = FL_DSET;
      FL_DSET: st_nxt = (sum_r == 10'd0) ? FL_MUL1 : FL_DIV;
      FL_DIV:  if (div_last) st_nxt = FL_MUL1;
      FL_MUL1: st_nxt = FL_MIX;
      FL_MIX:  st_nxt = FL_MUL2;
      FL_MUL2: st_nxt = FL_FIN;
      FL_FIN:  st_nxt = FL_IDLE;
      default: st_nxt = FL_IDLE;
    endcase
  end

  // outputs of the sequence
  always_comb begin
    acc_last = (st_r == FL_ACC) && (cnt_r[1:0] == 2'd3);
    div_last = (st_r == FL_DIV) && (cnt_r == 5'd23);
    fin      = (st_r == FL_FIN);
  end

  // operands; a missing neighbor reads as zero
  always_comb begin
    ac     = job_r.center.alpha;
    cc     = rgb(job_r.center);
    bg     = {fcfg.bg_blue, fcfg.bg_green, fcfg.bg_red};
    nb_cur = job_r.has[cnt_r[1:0]] ? job_r.nb[cnt_r[1:0]] : '0;
    w_cur  = (job_r.has[cnt_r[1:0]] && (nb_cur.alpha > ac)) ? (nb_cur.alpha - ac) : 8'd0;
    // alpha * 65536 / 255, exact: alpha * 257 plus one at full alpha
    f_in   = {1'b0, job.center.alpha, job.center.alpha} +
             17'(job.center.alpha == 8'hFF);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= FL_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= fin;
    end
  end

  // datapath, three color lanes
  always_ff @(posedge clk) begin
    logic [2:0][7:0] nc;
    logic [10:0]     trial;
    logic            ge;
    logic [24:0]     base;
    logic [24:0]     m2;
    nc = rgb(nb_cur);
    unique case (st_r)
      FL_IDLE: begin
        if (start) begin
          job_r <= job;
          cnt_r <= 5'd0;
          sum_r <= 10'd0;
          num_r <= '0;
          f_r   <= f_in;
          inv_r <= 17'h10000 - f_in;
        end
      end
      // accumulate one neighbor a cycle
      FL_ACC: begin
        cnt_r <= cnt_r + 5'd1;
        sum_r <= sum_r + 10'(w_cur);
        for (int k = 0; k < 3; k++) begin
          num_r[k] <= num_r[k] + 18'({8'd0, nc[k]} * {8'd0, w_cur});
        end
      end
      // quotient below 2^24, so the top dividend bits start as remainder
      FL_DSET: begin
        cnt_r <= 5'd0;
        for (int k = 0; k < 3; k++) begin
          rem_r[k] <= num_r[k][17:8];
          sh_r[k]  <= (sum_r == 10'd0) ? {cc[k], 16'd0} : {num_r[k][7:0], 16'd0};
        end
      end
      // restoring division, one quotient bit a cycle
      FL_DIV: begin
        cnt_r <= cnt_r + 5'd1;
        for (int k = 0; k < 3; k++) begin
          trial    = {rem_r[k], sh_r[k][23]};
          ge       = trial >= {1'b0, sum_r};
          rem_r[k] <= ge ? 10'(trial - {1'b0, sum_r}) : trial[9:0];
          sh_r[k]  <= {sh_r[k][22:0], ge};
        end
      end
      FL_MUL1: begin
        for (int k = 0; k < 3; k++) begin
          p1_r[k] <= 41'(sh_r[k]) * 41'(inv_r);
          cf_r[k] <= 25'(cc[k]) * 25'(f_r);
        end
      end
      // mix average with own color
      FL_MIX: begin
        for (int k = 0; k < 3; k++) begin
          m_r[k] <= 24'(p1_r[k][40:16] + cf_r[k]);
        end
      end
      FL_MUL2: begin
        for (int k = 0; k < 3; k++) begin
          p2_r[k]  <= 41'(m_r[k]) * 41'(f_r);
          bgi_r[k] <= 25'(bg[k]) * 25'(inv_r);
        end
      end
      // premultiply and background share the alpha product
      FL_FIN: begin
        for (int k = 0; k < 3; k++) begin
          base = (fcfg.premul || fcfg.blend) ? p2_r[k][40:16] : {1'b0, m_r[k]};
          m2   = base + (fcfg.blend ? bgi_r[k] : 25'd0);
          case (k)
            0:       res_r.red   <= m2[24] ? 8'hFF : m2[23:16];
            1:       res_r.green <= m2[24] ? 8'hFF : m2[23:16];
            default: res_r.blue  <= m2[24] ? 8'hFF : m2[23:16];
          endcase
        end
        res_r.col   <= job_r.col;
        res_r.row   <= job_r.row;
        res_r.alpha <= ac;
        res_r.done  <= job_r.done;
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

`default_nettype wire

FILE: src/alpha_edge_color_bleed.sv
// Alpha edge color bleed.
// Input channel in_ch: RGBA8 pixels in raster order. Output channel out_ch:
// finished pixels with column, row and image_done on the last pixel.
// A pixel is finished once its lower neighbor has arrived; on the last row a
// pixel also finishes the one to its left, and the last pixel itself, so one
// item gives zero to three results.
// Sequence per item: the accept in SQ_IDLE, three read states of two line-store
// reads each (the write-back goes with the last reads) and SQ_RD3 to capture the
// last words. Each result then goes through the filter and its 24-step divider by
// the weight sum, which is skipped when all weights are zero.
// One item is in work at a time; the next is taken when its last result has
// moved into the output register, even if that result is not yet taken.
// A stalled receiver holds the output register and, at the next result,
// the sequencer.
// Reset clears the sequencer, counters, configuration and handshake state, not the
// data registers or the line store; the line store needs no clearing pass. Writing
// width or height restarts the image at row 0, column 0.
`default_nettype none

module alpha_edge_color_bleed
  import aecb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  aecb_in_if.sink                    in_ch,
  aecb_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  function automatic logic [ADDR_W-1:0] mk_addr(logic par, logic [COL_W-1:0] col);
    return {par, col};
  endfunction

  // configuration
  logic [WID_W-1:0] img_w_r;
  logic [ROW_W-1:0] img_h_r;
  fcfg_t            fcfg_r;
  logic [WID_W-1:0] ew;
  logic [ROW_W-1:0] eh;

  // position and item
  logic [COL_W-1:0] col_cnt_r;
  logic [ROW_W-1:0] row_cnt_r;
  logic [COL_W-1:0] x_r;
  logic [ROW_W-1:0] y_r;
  pix_t             pix_r;
  logic [2:0]       mask_r;

  // fetched line-store words
  pix_t p_lm_r, p_m_r, p_rp_r, p_up_r, q_l1_r, q_l2_r;

  seq_state_t st_r, st_nxt;

  logic              in_ready;
  logic              accept;
  logic              load_ok;
  logic              push;
  logic              mem_we;
  logic [ADDR_W-1:0] raddr_a, raddr_b, waddr;
  pix_t              rd_a, rd_b;
  logic              f_start;
  logic              f_done;
  res_t              f_res;

  logic [COL_W-1:0]  xe;
  logic [ROW_W-1:0]  ye;
  logic [WID_W-1:0]  x1;
  logic [ROW_W:0]    y1;
  logic              last_row;
  pix_t              pix_in;

  logic [2:0]        cur_bit;
  logic [2:0]        mask_rest;
  job_t              job_a, job_b, job_c, job_cur;

  logic              out_valid_r;
  res_t              out_r;

  // effective geometry
  always_comb begin
    ew = img_w_r;
    if (img_w_r < WID_W'(2)) ew = WID_W'(2);
    if (img_w_r > WID_W'(MAX_WIDTH)) ew = WID_W'(MAX_WIDTH);
    eh = (img_h_r < ROW_W'(2)) ? ROW_W'(2) : img_h_r;
  end

  // position of the incoming item and the next one
  always_comb begin
    if ((WID_W'(col_cnt_r) >= ew) || (row_cnt_r >= eh)) begin
      xe = '0;
      ye = '0;
    end else begin
      xe = col_cnt_r;
      ye = row_cnt_r;
    end
    x1       = WID_W'(xe) + WID_W'(1);
    y1       = (ROW_W+1)'(ye) + (ROW_W+1)'(1);
    last_row = (ye == eh - ROW_W'(1));
    pix_in   = '{alpha: in_ch.in_alpha, blue: in_ch.in_blue,
                 green: in_ch.in_green, red: in_ch.in_red};
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      SQ_IDLE:  if (in_ch.valid) st_nxt = SQ_RD0;
      SQ_RD0:   st_nxt = SQ_RD1;
      SQ_RD1:   st_nxt = SQ_RD2;
      SQ_RD2:   st_nxt = SQ_RD3;
      SQ_RD3:   st_nxt = (mask_r == 3'd0) ? SQ_IDLE : SQ_START;
      SQ_START: st_nxt = SQ_WAIT;
      SQ_WAIT:  if (f_done) st_nxt = SQ_PUSH;
      SQ_PUSH:  if (load_ok) st_nxt = (mask_rest == 3'd0) ? SQ_IDLE : SQ_START;
      default:  st_nxt = SQ_IDLE;
    endcase
  end

  // sequencer outputs: input ready, line-store addresses, write-back, filter start, push
  always_comb begin
    in_ready = 1'b0;
    mem_we   = 1'b0;
    f_start  = 1'b0;
    push     = 1'b0;
    raddr_a  = mk_addr(~y_r[0], x_r - COL_W'(1));
    raddr_b  = mk_addr(~y_r[0], x_r);
    waddr    = mk_addr(y_r[0], x_r);
    unique case (st_r)
      SQ_IDLE: in_ready = 1'b1;
      SQ_RD0: begin
        raddr_a = mk_addr(~y_r[0], x_r - COL_W'(1));
        raddr_b = mk_addr(~y_r[0], x_r);
      end
      SQ_RD1: begin
        raddr_a = mk_addr(~y_r[0], x_r + COL_W'(1));
        raddr_b = mk_addr(y_r[0], x_r);
      end
      SQ_RD2: begin
        raddr_a = mk_addr(y_r[0], x_r - COL_W'(1));
        raddr_b = mk_addr(y_r[0], x_r - COL_W'(2));
        mem_we  = 1'b1;
      end
      SQ_START: f_start = 1'b1;
      SQ_PUSH:  push = load_ok;
      default: ;
    endcase
  end

  assign accept  = in_ch.valid && in_ready;
  assign load_ok = !out_valid_r || out_ch.ready;

  // jobs: pixel above, pixel to the left on the last row, the last pixel
  always_comb begin
    job_a.center          = p_m_r;
    job_a.nb[NB_LEFT]     = p_lm_r;
    job_a.nb[NB_UP]       = p_up_r;
    job_a.nb[NB_RIGHT]    = p_rp_r;
    job_a.nb[NB_DOWN]     = pix_r;
    job_a.has[NB_LEFT]    = (x_r != '0);
    job_a.has[NB_UP]      = (y_r >= ROW_W'(2));
    job_a.has[NB_RIGHT]   = (WID_W'(x_r) + WID_W'(1)) < ew;
    job_a.has[NB_DOWN]    = 1'b1;
    job_a.col             = x_r;
    job_a.row             = y_r - ROW_W'(1);
    job_a.done            = 1'b0;

    job_b.center          = q_l1_r;
    job_b.nb[NB_LEFT]     = q_l2_r;
    job_b.nb[NB_UP]       = p_lm_r;
    job_b.nb[NB_RIGHT]    = pix_r;
    job_b.nb[NB_DOWN]     = pix_r;
    job_b.has[NB_LEFT]    = (x_r >= COL_W'(2));
    job_b.has[NB_UP]      = 1'b1;
    job_b.has[NB_RIGHT]   = 1'b1;
    job_b.has[NB_DOWN]    = 1'b0;
    job_b.col             = x_r - COL_W'(1);
    job_b.row             = y_r;
    job_b.done            = 1'b0;

    job_c.center          = pix_r;
    job_c.nb[NB_LEFT]     = q_l1_r;
    job_c.nb[NB_UP]       = p_m_r;
    job_c.nb[NB_RIGHT]    = pix_r;
    job_c.nb[NB_DOWN]     = pix_r;
    job_c.has[NB_LEFT]    = 1'b1;
    job_c.has[NB_UP]      = 1'b1;
    job_c.has[NB_RIGHT]   = 1'b0;
    job_c.has[NB_DOWN]    = 1'b0;
    job_c.col             = x_r;
    job_c.row             = y_r;
    job_c.done            = 1'b1;

    if (mask_r[0]) begin
      cur_bit = 3'b001;
      job_cur = job_a;
    end else if (mask_r[1]) begin
      cur_bit = 3'b010;
      job_cur = job_b;
    end else begin
      cur_bit = 3'b100;
      job_cur = job_c;
    end
    mask_rest = mask_r & ~cur_bit;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= SQ_IDLE;
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
      img_w_r     <= WID_W'(MAX_WIDTH);
      img_h_r     <= ROW_W'(2);
      fcfg_r      <= '0;
    end else begin
      st_r <= st_nxt;
      if (accept) begin
        mask_r[0] <= (ye != '0);
        mask_r[1] <= last_row && (xe != '0);
        mask_r[2] <= last_row && (WID_W'(xe) == ew - WID_W'(1));
        if (x1 >= ew) begin
          col_cnt_r <= '0;
          row_cnt_r <= (y1 >= (ROW_W+1)'(eh)) ? '0 : y1[ROW_W-1:0];
        end else begin
          col_cnt_r <= x1[COL_W-1:0];
        end
      end
      if (push) begin
        mask_r <= mask_rest;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      // register writes
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IMAGE_WIDTH: begin
            img_w_r   <= cfg_wdata[WID_W-1:0];
            col_cnt_r <= '0;
            row_cnt_r <= '0;
          end
          CFG_IMAGE_HEIGHT: begin
            img_h_r   <= cfg_wdata[ROW_W-1:0];
            col_cnt_r <= '0;
            row_cnt_r <= '0;
          end
          CFG_PREMULTIPLY: fcfg_r.premul   <= cfg_wdata[0];
          CFG_BLEND:       fcfg_r.blend    <= cfg_wdata[0];
          CFG_BG_RED:      fcfg_r.bg_red   <= cfg_wdata[7:0];
          CFG_BG_GREEN:    fcfg_r.bg_green <= cfg_wdata[7:0];
          CFG_BG_BLUE:     fcfg_r.bg_blue  <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  // item and fetched words
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r   <= xe;
      y_r   <= ye;
      pix_r <= pix_in;
    end
    unique case (st_r)
      SQ_RD1: begin
        p_lm_r <= rd_a;
        p_m_r  <= rd_b;
      end
      SQ_RD2: begin
        p_rp_r <= rd_a;
        p_up_r <= rd_b;
      end
      SQ_RD3: begin
        q_l1_r <= rd_a;
        q_l2_r <= rd_b;
      end
      default: ;
    endcase
    if (push) begin
      out_r <= f_res;
    end
  end

  aecb_line_mem u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (waddr),
    .wdata   (pix_r),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  aecb_filter u_filter (
    .clk   (clk),
    .rst_n (rst_n),
    .start (f_start),
    .job   (job_cur),
    .fcfg  (fcfg_r),
    .done  (f_done),
    .res   (f_res)
  );

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_col    = out_r.col;
  assign out_ch.out_row    = out_r.row;
  assign out_ch.out_red    = out_r.red;
  assign out_ch.out_green  = out_r.green;
  assign out_ch.out_blue   = out_r.blue;
  assign out_ch.out_alpha  = out_r.alpha;
  assign out_ch.image_done = out_r.done;

endmodule

`default_nettype wire

FILE: verif/alpha_edge_color_bleed_tb.sv
`timescale 1ns / 100ps

module alpha_edge_color_bleed_tb;
  import aecb_pkg::*;

  localparam int unsigned ONE_Q16 = 65536;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 200;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  aecb_in_if in_bus();
  aecb_out_if out_bus();

  alpha_edge_color_bleed dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_bus),
    .out_ch(out_bus),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Predictor state: registers, raster position and the two line banks
  int unsigned img_width = 2048;
  int unsigned img_height = 2;
  bit premul_on = 0;
  bit blend_on = 0;
  int unsigned bg_color [3] = '{0, 0, 0};
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  pix_t line_mem [2*MAX_WIDTH];

  res_t pixel_q [$];
  int errors = 0;
  int items_sent = 0;
  int pixels_checked = 0;
  int images_done = 0;
  int tx_idle = 0;
  int rx_idle = 0;
  int hold_left = 0;
  int cycles = 0;

  // Clock and reset
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels pending", cycles, pixel_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stalls plus long hold-offs on request
  initial begin
    out_bus.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d (pixel %0d)", what, got, want, pixels_checked);
  endtask

  // Compare each finished pixel with the oldest prediction
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pixel_q.size() == 0) begin
        report("unexpected pixel col", out_bus.out_col, -1);
      end else begin
        want = pixel_q.pop_front();
        if (out_bus.out_col !== want.col) report("col", out_bus.out_col, want.col);
        if (out_bus.out_row !== want.row) report("row", out_bus.out_row, want.row);
        if (out_bus.out_red !== want.red) report("red", out_bus.out_red, want.red);
        if (out_bus.out_green !== want.green) report("green", out_bus.out_green, want.green);
        if (out_bus.out_blue !== want.blue) report("blue", out_bus.out_blue, want.blue);
        if (out_bus.out_alpha !== want.alpha) report("alpha", out_bus.out_alpha, want.alpha);
        if (out_bus.image_done !== want.done) report("done", out_bus.image_done, want.done);
        if (want.done) images_done++;
      end
      pixels_checked++;
    end
  end

  function automatic int unsigned eff_width();
    if (img_width < 2) return 2;
    if (img_width > MAX_WIDTH) return MAX_WIDTH;
    return img_width;
  endfunction

  function automatic int unsigned line_addr(int unsigned r, int unsigned c);
    return (r & 1) * MAX_WIDTH + (c % MAX_WIDTH);
  endfunction

  function automatic logic [7:0] chan_of(pix_t p, int k);
    case (k)
      0: return p.red;
      1: return p.green;
      default: return p.blue;
    endcase
  endfunction

  // Append one prediction at the tail of the queue
  function automatic void queue_pixel(res_t r);
    pixel_q = {pixel_q, r};
  endfunction

  // Weighted neighbor average, alpha mix, premultiply and background blend
  function automatic res_t bleed_pixel(int unsigned col, int unsigned row, pix_t ctr,
                                       pix_t nb [4], bit has [4], bit done);
    res_t r;
    longint unsigned f, inv, wsum, c, avg, m, bgq, v, wt;
    longint unsigned num [3];
    f = (longint'(ctr.alpha) * ONE_Q16) / 255;
    inv = ONE_Q16 - f;
    wsum = 0;
    num = '{0, 0, 0};
    for (int i = 0; i < 4; i++) begin
      if (has[i]) begin
        wt = (nb[i].alpha > ctr.alpha) ? nb[i].alpha - ctr.alpha : 0;
        wsum += wt;
        for (int k = 0; k < 3; k++) num[k] += longint'(chan_of(nb[i], k)) * wt;
      end
    end
    r.col = col[COL_W-1:0];
    r.row = row[15:0];
    r.alpha = ctr.alpha;
    r.done = done;
    for (int k = 0; k < 3; k++) begin
      c = chan_of(ctr, k);
      avg = (wsum != 0) ? (num[k] * ONE_Q16) / wsum : c * ONE_Q16;
      m = (avg * inv + c * ONE_Q16 * f) >> 16;
      bgq = longint'(bg_color[k]) * ONE_Q16;
      if (premul_on) begin
        m = (m * f) >> 16;
        if (blend_on) m += (bgq * inv) >> 16;
      end else if (blend_on) begin
        m = (bgq * inv + m * f) >> 16;
      end
      v = m >> 16;
      if (v > 255) v = 255;
      case (k)
        0: r.red = v[7:0];
        1: r.green = v[7:0];
        default: r.blue = v[7:0];
      endcase
    end
    return r;
  endfunction

  // Advance the raster position by one pixel and queue what it finishes
  function automatic void bleed_step(pix_t p);
    int unsigned w, h, x, y;
    pix_t nb [4];
    bit has [4];
    w = eff_width();
    h = (img_height < 2) ? 2 : img_height;
    x = col_pos;
    y = row_pos;
    if (x >= w || y >= h) begin
      x = 0;
      y = 0;
    end
    if (y >= 1) begin
      has = '{x > 0, y >= 2, x + 1 < w, 1'b1};
      nb[0] = has[0] ? line_mem[line_addr(y - 1, x - 1)] : '0;
      nb[1] = has[1] ? line_mem[line_addr(y, x)] : '0;
      nb[2] = has[2] ? line_mem[line_addr(y - 1, x + 1)] : '0;
      nb[3] = p;
      queue_pixel(bleed_pixel(x, y - 1, line_mem[line_addr(y - 1, x)], nb, has, 0));
    end
    line_mem[line_addr(y, x)] = p;
    if (y == h - 1) begin
      if (x > 0) begin
        has = '{x >= 2, 1'b1, 1'b1, 1'b0};
        nb[0] = has[0] ? line_mem[line_addr(y, x - 2)] : '0;
        nb[1] = line_mem[line_addr(y - 1, x - 1)];
        nb[2] = p;
        nb[3] = '0;
        queue_pixel(bleed_pixel(x - 1, y, line_mem[line_addr(y, x - 1)], nb, has, 0));
      end
      if (x == w - 1) begin
        has = '{1'b1, 1'b1, 1'b0, 1'b0};
        nb[0] = line_mem[line_addr(y, x - 1)];
        nb[1] = line_mem[line_addr(y - 1, x)];
        nb[2] = '0;
        nb[3] = '0;
        queue_pixel(bleed_pixel(x, y, p, nb, has, 1));
      end
    end
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) y = 0;
    end
    col_pos = x;
    row_pos = y;
  endfunction

  // Send one pixel; returns right after the accepting edge
  task automatic send_pixel(pix_t p);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle) begin
      in_bus.valid <= 0;
      @(negedge clk);
    end
    in_bus.valid <= 1;
    in_bus.in_red <= p.red;
    in_bus.in_green <= p.green;
    in_bus.in_blue <= p.blue;
    in_bus.in_alpha <= p.alpha;
    do @(posedge clk); while (!in_bus.ready);
    bleed_step(p);
    items_sent++;
  endtask

  // Stop sending, wait for all predicted pixels, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_bus.valid <= 0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_IMAGE_WIDTH: begin
        img_width = val & 12'hFFF;
        col_pos = 0;
        row_pos = 0;
      end
      CFG_IMAGE_HEIGHT: begin
        img_height = val & 16'hFFFF;
        col_pos = 0;
        row_pos = 0;
      end
      CFG_PREMULTIPLY: premul_on = val[0];
      CFG_BLEND: blend_on = val[0];
      CFG_BG_RED: bg_color[0] = val & 8'hFF;
      CFG_BG_GREEN: bg_color[1] = val & 8'hFF;
      CFG_BG_BLUE: bg_color[2] = val & 8'hFF;
      default: ;
    endcase
  endtask

  task automatic set_mode(bit pm, bit bl, int unsigned r, int unsigned g, int unsigned b);
    cfg_write(CFG_PREMULTIPLY, pm);
    cfg_write(CFG_BLEND, bl);
    cfg_write(CFG_BG_RED, r);
    cfg_write(CFG_BG_GREEN, g);
    cfg_write(CFG_BG_BLUE, b);
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h);
    cfg_write(CFG_IMAGE_WIDTH, w);
    cfg_write(CFG_IMAGE_HEIGHT, h);
  endtask

  // Alpha biased toward the extremes so weights vary
  function automatic pix_t rand_pixel();
    pix_t p;
    p = $urandom;
    case ($urandom_range(3))
      0: p.alpha = 8'd0;
      1: p.alpha = 8'd255;
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_image(int unsigned w, int unsigned h);
    for (int i = 0; i < w * h; i++) send_pixel(rand_pixel());
  endtask

  // Extreme pixel values on a clamped 2x2 image
  task automatic test_extremes();
    drain();
    set_geometry(0, 0);
    set_mode(0, 0, 0, 0, 0);
    send_pixel('{alpha: 8'd0, blue: 8'd255, green: 8'd0, red: 8'd255});
    send_pixel('{alpha: 8'd255, blue: 8'd0, green: 8'd255, red: 8'd0});
    send_pixel('{alpha: 8'd255, blue: 8'd255, green: 8'd255, red: 8'd255});
    send_pixel('{alpha: 8'd0, blue: 8'd0, green: 8'd0, red: 8'd0});
  endtask

  // All weights zero: each pixel keeps its own color
  task automatic test_flat_alpha();
    pix_t p;
    drain();
    set_geometry(3, 3);
    for (int i = 0; i < 9; i++) begin
      p = $urandom;
      p.alpha = 8'd128;
      send_pixel(p);
    end
  endtask

  // Every premultiply / blend combination, background red and blue at both extremes
  task automatic test_modes();
    for (int m = 0; m < 4; m++) begin
      drain();
      set_mode(m[1], m[0], m[0] ? 255 : 0, 255, m[1] ? 0 : 255);
      set_geometry(2, 2);
      send_image(2, 2);
    end
  endtask

  // Width beyond the line store and the tallest height, then abandoned
  task automatic test_geometry_limits();
    drain();
    set_geometry(4095, 2);
    for (int i = 0; i < 3; i++) send_pixel(rand_pixel());
    drain();
    set_geometry(2, 65535);
    send_image(2, 3);
  endtask

  // Random images, each under a random mode
  task automatic test_random_images(int unsigned item_goal, bit hold);
    int unsigned w, h;
    int unsigned stop_at;
    stop_at = items_sent + item_goal;
    while (items_sent < stop_at) begin
      drain();
      w = $urandom_range(2, 6);
      h = $urandom_range(2, 4);
      set_geometry(w, h);
      set_mode($urandom_range(1), $urandom_range(1), $urandom_range(255),
               $urandom_range(255), $urandom_range(255));
      if (hold) begin
        hold_left = 600;
        hold = 0;
      end
      send_image(w, h);
    end
  endtask

  initial begin
    cfg_we = 0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_bus.valid = 0;
    in_bus.in_red = '0;
    in_bus.in_green = '0;
    in_bus.in_blue = '0;
    in_bus.in_alpha = '0;
    @(posedge rst_n);
    test_extremes();
    test_flat_alpha();
    test_modes();
    test_geometry_limits();
    tx_idle = 11;
    rx_idle = 79;
    test_random_images(35, 1);
    tx_idle = 79;
    rx_idle = 11;
    test_random_images(35, 0);
    tx_idle = 0;
    rx_idle = 0;
    test_random_images(35, 1);
    drain();
    $display("sent %0d pixels, checked %0d finished pixels over %0d complete images",
             items_sent, pixels_checked, images_done);
    $display("modes: all premultiply/blend pairs, clamped and random geometries, stalls");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
